FILE: hdl/cfd_pkg.sv
// ----------------------------------------------------------------------------
// cfd_pkg
// Shared types and constants of the COBS frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package cfd_pkg;

  // Item operations carried in the input tuser field.
  typedef enum logic [1:0] {
    OP_RECEIVE = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_READ    = 2'd2
  } op_e;

  localparam int unsigned DataW   = 8;
  localparam int unsigned IndexW  = 6;
  localparam int unsigned CountW  = 7;
  localparam int unsigned LimitW  = 8;

  localparam logic [LimitW-1:0] LimitReset = 8'd64;

  // Decoder status after one item.
  typedef struct packed {
    logic              awaiting_code;
    logic              fault;
    logic              frame_complete;
    logic [CountW-1:0] byte_count;
  } cfd_status_t;

endpackage

`default_nettype wire

FILE: hdl/cobs_frame_decoder.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder
// Usage:
//   The slave stream carries one item per beat: tuser holds the operation
//   (receive byte, clear, read entry), tdata the line byte and read index.
//   Every item gives exactly one result beat on the master stream with the
//   read data (zero unless a read) and the status after that item: byte
//   count, frame complete, sticky fault and awaiting code.
//   The cfg channel writes the store limit; it is always ready and is meant
//   to be written only while no item is in flight.
// Timing:
//   An item accepted at one clock edge is held in the input register; its
//   state update and store access happen as it moves to the result register.
//   One item per cycle is sustained while the receiver takes results; the
//   single store write/read port and the count update set that figure.
// Reset and stall:
//   Reset clears count, code position and fault and sets the limit to 64.
//   Store contents are not cleared. When the receiver stalls, the result
//   is held, one more item waits in the input register, and tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module cobs_frame_decoder import cfd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // cfg: store_limit[7:0]
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [7:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  // tdata: data_byte[7:0], read_index[13:8], zero[15:14]
  input  wire logic [15:0] s_axis_tdata_i,
  // tuser: operation[1:0]
  input  wire logic [1:0]  s_axis_tuser_i,
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  // tdata: read_data[7:0], byte_count[14:8], frame_complete[15], fault[16],
  //        awaiting_code[17], zero[23:18]
  output logic      [23:0] m_axis_tdata_o
);

  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam logic [7:0]  DepthB = 8'(STORE_DEPTH);

  logic [LimitW-1:0] limit_q;

  logic              s1_valid_q;
  op_e               s1_op_q;
  logic [DataW-1:0]  s1_byte_q;
  logic [IndexW-1:0] s1_idx_q;
  logic              s1_adv;
  logic              s1_upd;

  logic              out_valid_q;
  cfd_status_t       out_status_q;
  logic              out_rd_q;

  logic [7:0]        idx8;
  logic              rd_hit;
  logic              we;
  logic [AddrW-1:0]  waddr;
  logic [DataW-1:0]  wdata;
  logic [DataW-1:0]  rdata;
  logic [DataW-1:0]  read_data;
  cfd_status_t       status;

  assign cfg_ready_o     = 1'b1;
  assign s1_adv          = !out_valid_q || m_axis_tready_i;
  assign s1_upd          = s1_valid_q && s1_adv;
  assign s_axis_tready_o = !s1_valid_q || s1_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      limit_q <= cfg_data_i;
    end
  end

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      s1_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      s1_op_q   <= op_e'(s_axis_tuser_i);
      s1_byte_q <= s_axis_tdata_i[7:0];
      s1_idx_q  <= s_axis_tdata_i[13:8];
    end
  end

  cfd_ctrl #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .upd_i    (s1_upd),
    .op_i     (s1_op_q),
    .byte_i   (s1_byte_q),
    .limit_i  (limit_q),
    .we_o     (we),
    .waddr_o  (waddr),
    .wdata_o  (wdata),
    .status_o (status)
  );

  // Reads beyond the store depth answer zero and never touch the RAM.
  assign idx8   = 8'(s1_idx_q);
  assign rd_hit = (s1_op_q == OP_READ) && (idx8 < DepthB);

  cfd_ram #(
    .WIDTH(DataW),
    .DEPTH(STORE_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (s1_upd && rd_hit),
    .raddr_i (idx8[AddrW-1:0]),
    .rdata_o (rdata)
  );

  // Result register; the RAM read data register holds alongside it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_upd) begin
      out_status_q <= status;
      out_rd_q     <= rd_hit;
    end
  end

  assign read_data       = out_rd_q ? rdata : '0;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_status_q.awaiting_code, out_status_q.fault,
                            out_status_q.frame_complete, out_status_q.byte_count,
                            read_data};

endmodule

`default_nettype wire

FILE: hdl/cfd_ram.sv
// ----------------------------------------------------------------------------
// cfd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/cfd_ctrl.sv
// ----------------------------------------------------------------------------
// cfd_ctrl
// Decoder state: stored count, next zero position and overflow flag, with
// the store write for each received byte that is stored.
// ----------------------------------------------------------------------------
`default_nettype none

module cfd_ctrl import cfd_pkg::*; #(
  parameter int unsigned STORE_DEPTH = 64,
  localparam int unsigned AddrW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              upd_i,
  input  wire op_e               op_i,
  input  wire logic [DataW-1:0]  byte_i,
  input  wire logic [LimitW-1:0] limit_i,
  output logic                   we_o,
  output logic      [AddrW-1:0]  waddr_o,
  output logic      [DataW-1:0]  wdata_o,
  output cfd_status_t            status_o
);

  localparam int unsigned CntW = $clog2(STORE_DEPTH + 1);
  localparam logic [LimitW-1:0] DepthB = LimitW'(STORE_DEPTH);

  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [DataW-1:0]  nz_q, nz_d;
  logic              flt_q, flt_d;
  logic [LimitW-1:0] eff_limit;
  logic [7:0]        cnt8, cnt8_d, cnt_inc;

  assign eff_limit = (limit_i > DepthB) ? DepthB : limit_i;
  assign cnt8      = 8'(cnt_q);
  assign cnt_inc   = cnt8 + 8'd1;
  assign waddr_o   = cnt8[AddrW-1:0];

  always_comb begin
    cnt_d   = cnt_q;
    nz_d    = nz_q;
    flt_d   = flt_q;
    we_o    = 1'b0;
    wdata_o = byte_i;
    if (upd_i) begin
      unique case (op_i)
        OP_RECEIVE: begin
          if (nz_q == '0) begin
            nz_d = byte_i;
          end else if (byte_i == '0) begin
            nz_d = '0;
          end else if (cnt8 < eff_limit) begin
            we_o  = 1'b1;
            cnt_d = CntW'(cnt_inc);
            // Reaching the coded position stores a zero; the byte is the
            // next code, relative to the new count.
            if (cnt_inc == nz_q) begin
              wdata_o = '0;
              nz_d    = byte_i + cnt_inc;
            end
          end else begin
            flt_d = 1'b1;
          end
        end
        OP_CLEAR: begin
          cnt_d = '0;
          nz_d  = '0;
          flt_d = 1'b0;
        end
        OP_READ: begin
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      nz_q  <= '0;
      flt_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      nz_q  <= nz_d;
      flt_q <= flt_d;
    end
  end

  assign cnt8_d                  = 8'(cnt_d);
  assign status_o.byte_count     = cnt8_d[CountW-1:0];
  assign status_o.awaiting_code  = (nz_d == '0);
  assign status_o.frame_complete = (cnt_d != '0) && (nz_d == '0);
  assign status_o.fault          = flt_d;

endmodule

`default_nettype wire

FILE: sim/cobs_frame_decoder_test.sv
// ----------------------------------------------------------------------------
// cobs_frame_decoder_test
// Self-checking testbench for the COBS frame decoder. A queue of items
// (line bytes, clears, store reads) is streamed into the block in random
// bursts while the result stream stalls on its own pattern. Each accepted
// item is run through a decoder model in the testbench, and every result
// beat is checked against the oldest predicted result. The run steps
// through several store limits, written while the block is idle.
// ----------------------------------------------------------------------------

module cobs_frame_decoder_test import cfd_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned Depth      = 64;
  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned PhaseItems = 215;

  typedef struct {
    op_e               op;
    logic [DataW-1:0]  data;
    logic [IndexW-1:0] index;
  } line_item_t;

  typedef struct packed {
    cfd_status_t      status;
    logic [DataW-1:0] read_data;
  } decode_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [7:0]  cfg_data_i = '0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  // tdata: data_byte[7:0], read_index[13:8], zero[15:14]
  logic [15:0] s_axis_tdata_i = '0;
  // tuser: operation[1:0]
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  // tdata: read_data[7:0], byte_count[14:8], frame_complete[15], fault[16],
  //        awaiting_code[17], zero[23:18]
  logic [23:0] m_axis_tdata_o;

  cobs_frame_decoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_data_i     (cfg_data_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  always #5 clk_i = ~clk_i;

  line_item_t     pending_items[$];
  decode_result_t expected_beats[$];
  int unsigned    mismatches = 0;
  int unsigned    cycles = 0;
  bit             sending = 1'b0;

  // Decoder state as the testbench sees it.
  logic [DataW-1:0]  store_copy [Depth];
  logic [7:0]        count_copy = '0;
  logic [7:0]        zero_pos_copy = '0;
  bit                fault_copy = 1'b0;
  logic [LimitW-1:0] limit_copy = LimitReset;
  // Entries are only ever written at the current count, so the written
  // part of the store is always a prefix of this length.
  int unsigned       written_len = 0;

  function automatic decode_result_t decode_line_item(line_item_t it);
    decode_result_t r;
    logic [7:0]     lim;
    r = '0;
    lim = (limit_copy > Depth) ? 8'(Depth) : limit_copy;
    case (it.op)
      OP_RECEIVE: begin
        if (zero_pos_copy == 8'd0) begin
          zero_pos_copy = it.data;
        end else if (it.data == 8'd0) begin
          zero_pos_copy = 8'd0;
        end else if (count_copy < lim) begin
          if (count_copy + 8'd1 == zero_pos_copy) begin
            store_copy[count_copy] = 8'd0;
            count_copy = count_copy + 8'd1;
            zero_pos_copy = it.data + count_copy;
          end else begin
            store_copy[count_copy] = it.data;
            count_copy = count_copy + 8'd1;
          end
          if (count_copy > written_len) written_len = count_copy;
        end else begin
          fault_copy = 1'b1;
        end
      end
      OP_CLEAR: begin
        count_copy = 8'd0;
        zero_pos_copy = 8'd0;
        fault_copy = 1'b0;
      end
      OP_READ: begin
        r.read_data = store_copy[it.index];
      end
      default: ;
    endcase
    r.status.byte_count = count_copy[CountW-1:0];
    r.status.frame_complete = (count_copy != 8'd0) && (zero_pos_copy == 8'd0);
    r.status.fault = fault_copy;
    r.status.awaiting_code = (zero_pos_copy == 8'd0);
    return r;
  endfunction

  // Sender: bursts of beats separated by random gaps; a beat once offered
  // stays on the bus until taken.
  line_item_t  cur_item;
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (sending && s_axis_tready_o) begin
        expected_beats.push_back(decode_line_item(cur_item));
        sending = 1'b0;
      end
      if (!sending) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          // Reads are aimed at entries that have been written by now.
          if (cur_item.op == OP_READ) begin
            if (written_len == 0) cur_item.op = OP_CLEAR;
            else cur_item.index = IndexW'(int'(cur_item.index) % written_len);
          end
          sending = 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                     : $urandom_range(1, 12);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
    s_axis_tvalid_i <= sending;
    s_axis_tuser_i <= cur_item.op;
    s_axis_tdata_i <= {2'b00, cur_item.index, cur_item.data};
  end

  // Receiver stalls follow a random mode, redrawn when its random-length run ends.
  int unsigned stall_mode = 0;
  int unsigned mode_left = 200;

  always @(posedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left = $urandom_range(64, 256);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: m_axis_tready_i <= 1'b1;
      1: m_axis_tready_i <= ($urandom_range(0, 9) >= 3);
      2: m_axis_tready_i <= (cycles[2:0] != 3'd0);
      default: m_axis_tready_i <= ($urandom_range(0, 9) >= 7);
    endcase
  end

  function automatic void note_mismatch(decode_result_t want, decode_result_t got,
                                        bit unexpected);
    mismatches++;
    if (mismatches <= 10) begin
      if (unexpected) begin
        $display("%0t: unexpected result beat: data %02h cnt %0d fc %0b f %0b aw %0b",
                 $realtime, got.read_data, got.status.byte_count,
                 got.status.frame_complete, got.status.fault, got.status.awaiting_code);
      end else begin
        $display("%0t: mismatch: expected data %02h cnt %0d fc %0b f %0b aw %0b",
                 $realtime, want.read_data, want.status.byte_count,
                 want.status.frame_complete, want.status.fault,
                 want.status.awaiting_code);
        $display("%0t:           actual   data %02h cnt %0d fc %0b f %0b aw %0b",
                 $realtime, got.read_data, got.status.byte_count,
                 got.status.frame_complete, got.status.fault, got.status.awaiting_code);
      end
    end
  endfunction

  always @(posedge clk_i) begin
    decode_result_t want;
    decode_result_t got;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = m_axis_tdata_o[17:0];
      if (expected_beats.size() == 0) begin
        note_mismatch('0, got, 1'b1);
      end else begin
        want = expected_beats.pop_front();
        if (got.read_data != want.read_data ||
            got.status.byte_count != want.status.byte_count ||
            got.status.frame_complete != want.status.frame_complete ||
            got.status.fault != want.status.fault ||
            got.status.awaiting_code != want.status.awaiting_code)
          note_mismatch(want, got, 1'b0);
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  int unsigned items_queued = 0;

  task automatic push_item(op_e op, logic [7:0] data, logic [5:0] index);
    line_item_t it;
    it.op = op;
    it.data = data;
    it.index = index;
    pending_items.push_back(it);
    items_queued++;
  endtask

  task automatic push_byte(logic [7:0] data);
    push_item(OP_RECEIVE, data, 6'($urandom()));
  endtask

  // Encodes a random payload with COBS and sends it with its delimiter;
  // now and then one line byte is corrupted.
  task automatic push_frame(int unsigned len);
    logic [7:0]  enc[$];
    logic [7:0]  b;
    int unsigned code_at;
    int unsigned code;
    code_at = 0;
    code = 1;
    enc.push_back(8'd0);
    for (int unsigned i = 0; i < len; i++) begin
      b = ($urandom_range(0, 3) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
      if (b == 8'd0) begin
        enc[code_at] = 8'(code);
        code_at = enc.size();
        enc.push_back(8'd0);
        code = 1;
      end else begin
        enc.push_back(b);
        code++;
      end
    end
    enc[code_at] = 8'(code);
    if ($urandom_range(0, 7) == 0) enc[$urandom_range(0, enc.size() - 1)] = 8'($urandom());
    foreach (enc[i]) push_byte(enc[i]);
    push_byte(8'd0);
  endtask

  task automatic push_random_items(int unsigned n);
    int unsigned start;
    int unsigned pick;
    start = items_queued;
    while (items_queued - start < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        if ($urandom_range(0, 2) == 0) push_item(OP_CLEAR, 8'($urandom()), 6'($urandom()));
        push_frame(($urandom_range(0, 9) == 0) ? $urandom_range(30, 70)
                                               : $urandom_range(1, 12));
      end else if (pick < 70) begin
        repeat ($urandom_range(1, 3)) push_item(OP_READ, 8'($urandom()), 6'($urandom()));
      end else if (pick < 78) begin
        push_item(OP_CLEAR, 8'($urandom()), 6'($urandom()));
      end else begin
        repeat ($urandom_range(1, 5)) push_byte(8'($urandom()));
      end
    end
  endtask

  // Holds off until the queue has drained and every result has come back.
  task automatic wait_idle();
    while (pending_items.size() > 0 || sending || expected_beats.size() > 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [7:0] value);
    wait_idle();
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    limit_copy = value;
  endtask

  initial begin
    logic [7:0] limits[6];
    limits = '{8'd0, 8'd255, 8'd1, 8'd37, 8'd65, 8'd64};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed opening at the reset limit of 64.
    push_item(OP_CLEAR, 8'hFF, 6'h3F);
    push_byte(8'h00);                    // zero as a code keeps awaiting a code
    push_byte(8'h03);
    push_byte(8'hFF);
    push_byte(8'h01);
    push_byte(8'h02);                    // zero stored, next code 2 + 3
    push_byte(8'h80);
    push_byte(8'h00);                    // end of frame
    push_byte(8'h01);                    // coded position already passed
    push_byte(8'h55);
    push_byte(8'h66);
    push_byte(8'h00);
    push_byte(8'h07);
    push_byte(8'hF9);                    // code sum wraps to zero
    push_byte(8'h00);
    push_item(OP_READ, 8'h00, 6'd0);
    push_item(OP_READ, 8'hFF, 6'd3);
    push_item(OP_READ, 8'h00, 6'd6);
    push_item(OP_CLEAR, 8'h00, 6'd0);
    push_item(OP_READ, 8'h00, 6'd2);     // store contents survive a clear
    push_random_items(PhaseItems);

    foreach (limits[i]) begin
      write_limit(limits[i]);
      if (limits[i] == 8'd0) begin
        // With no room at all, a data byte raises the sticky fault.
        push_byte(8'h05);
        push_byte(8'h42);
        push_byte(8'h43);
        push_item(OP_CLEAR, 8'h00, 6'd0);
      end
      push_random_items(PhaseItems);
    end

    wait_idle();
    repeat (10) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
